// File: rtl/ezr_pkg.sv
// Package for the ZYX Euler rotation matrix block: widths, CORDIC constants,
// transfer structs and the fixed-point rounding helpers.
// No dependencies.
`default_nettype none

package ezr_pkg;

  // Field widths
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int OUT_W      = FRAC_BITS + 2;

  // CORDIC datapath: 32-bit binary angle (2^32 = 2*pi), Q30 vectors
  localparam int WORD_W       = 32;
  localparam int Q_BITS       = 30;
  // sign, integer bit and fraction, so that +1.0 is representable
  localparam int TRIG_W       = Q_BITS + 2;
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int NUM_LANES    = 3;
  localparam int PROD_W       = 2 * TRIG_W;
  localparam int SUM_W        = 64;

  localparam int LANE_YAW   = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_ROLL  = 2;

  // prep + cells + post + five product stages, counted to the edge that takes the result
  localparam int LATENCY = CORDIC_STEPS + 7;

  localparam logic signed [WORD_W-1:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [WORD_W-1:0] ONE_Q30     = WORD_W'(1) << Q_BITS;

  localparam int OUT_SHIFT = 2 * Q_BITS - FRAC_BITS;
  localparam logic signed [SUM_W-1:0]  RND_OUT = SUM_W'(1) << (OUT_SHIFT - 1);
  localparam logic signed [SUM_W-1:0]  OUT_ONE = SUM_W'(1) << FRAC_BITS;
  localparam logic signed [PROD_W-1:0] RND_Q30 = PROD_W'(1) << (Q_BITS - 1);

  // atan(2^-i) as a binary angle
  localparam logic signed [WORD_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
    32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
    32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9,
    32'sh0000517C, 32'sh000028BE, 32'sh0000145F, 32'sh00000A2F, 32'sh00000517,
    32'sh0000028B, 32'sh00000145, 32'sh000000A2, 32'sh00000051, 32'sh00000028,
    32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000002, 32'sh00000001
  };

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] yaw_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] roll_angle;
  } ezr_angles_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] m00;
    logic signed [OUT_W-1:0] m01;
    logic signed [OUT_W-1:0] m02;
    logic signed [OUT_W-1:0] m10;
    logic signed [OUT_W-1:0] m11;
    logic signed [OUT_W-1:0] m12;
    logic signed [OUT_W-1:0] m20;
    logic signed [OUT_W-1:0] m21;
    logic signed [OUT_W-1:0] m22;
  } ezr_matrix_t;

  // One CORDIC lane in flight
  typedef struct packed {
    logic signed [WORD_W-1:0] x;
    logic signed [WORD_W-1:0] y;
    logic signed [WORD_W-1:0] z;
    logic                     neg;
  } ezr_lane_t;

  typedef struct packed {
    logic                          valid;
    ezr_lane_t [NUM_LANES-1:0]     lane;
  } ezr_cell_bus_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cy;
    logic signed [TRIG_W-1:0] sy;
    logic signed [TRIG_W-1:0] cp;
    logic signed [TRIG_W-1:0] sp;
    logic signed [TRIG_W-1:0] cr;
    logic signed [TRIG_W-1:0] sr;
  } ezr_trig_t;

  typedef struct packed {
    logic      valid;
    ezr_trig_t trig;
  } ezr_trig_bus_t;

  // Clamp a CORDIC result to +-1.0 in Q30
  function automatic logic signed [TRIG_W-1:0] clamp_unit(input logic signed [WORD_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    r = v;
    if (v > ONE_Q30) r = ONE_Q30;
    else if (v < -ONE_Q30) r = -ONE_Q30;
    return TRIG_W'(r);
  endfunction

  // Q60 product rounded back to Q30
  function automatic logic signed [TRIG_W-1:0] round_q30(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    r = (p + RND_Q30) >>> Q_BITS;
    return TRIG_W'(r);
  endfunction

  // Q60 entry rounded to the output format and saturated to +-1.0
  function automatic logic signed [OUT_W-1:0] to_q_out(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = (v + RND_OUT) >>> OUT_SHIFT;
    if (r > OUT_ONE) r = OUT_ONE;
    else if (r < -OUT_ONE) r = -OUT_ONE;
    return OUT_W'(r);
  endfunction

endpackage

`default_nettype wire

// File: rtl/euler_zyx_rotation_matrix.sv
// Top level of the ZYX Euler angle to rotation matrix block.
// Depends on ezr_pkg, ezr_cordic_chain and ezr_matrix.
//
// Usage:
//   Input channel: drive angles (yaw, pitch, roll as signed binary angles,
//   full scale = pi) and pulse start. A transfer happens at each rising edge
//   with start high and busy low. busy is held low: the block is fully
//   pipelined and takes a new item every cycle.
//   Result channel: done is high for one cycle while matrix holds the nine
//   entries of Rz(yaw)*Ry(pitch)*Rx(roll) in Q1.14, saturated to +-1.0.
//   The result transfer completes at the edge that ends that cycle; the
//   receiver cannot stall, so no result is ever held back.
//   Pipeline: from the start transfer to the result transfer an item passes
//   one fold register, 30 CORDIC cells (one rotation step each, three angle
//   lanes side by side), one sign/clamp register, then five product stages
//   (multiply, round, multiply, sum, round/saturate).
//   Throughput: one item per cycle, results in input order.
//   Reset: rst (synchronous) clears every valid bit in the pipeline; items
//   in flight are dropped and no done pulse follows them.
`default_nettype none

module euler_zyx_rotation_matrix import ezr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  ezr_angles_t angles,
  output logic        done,
  output ezr_matrix_t matrix
);

  ezr_trig_bus_t trig;

  // Never stalls: every cycle is a slot in the pipeline
  assign busy = 1'b0;

  ezr_cordic_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .angles   (angles),
    .trig_out (trig)
  );

  ezr_matrix u_matrix (
    .clk     (clk),
    .rst     (rst),
    .trig_in (trig),
    .done    (done),
    .matrix  (matrix)
  );

endmodule

`default_nettype wire

// File: rtl/ezr_cordic_cell.sv
// One CORDIC rotation step for all three angle lanes, registered.
// Depends on ezr_pkg.
`default_nettype none

module ezr_cordic_cell import ezr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [STEP_W-1:0]   step,
  input  ezr_cell_bus_t       cell_in,
  output ezr_cell_bus_t       cell_out
);

  logic                      valid;
  ezr_lane_t [NUM_LANES-1:0] lane;
  ezr_lane_t [NUM_LANES-1:0] lane_next;
  logic signed [WORD_W-1:0]  angle_step;

  always_comb begin
    angle_step = ATAN_TAB[step];
    for (int i = 0; i < NUM_LANES; i++) begin
      logic signed [WORD_W-1:0] xo, yo, zo, dx, dy;
      xo = cell_in.lane[i].x;
      yo = cell_in.lane[i].y;
      zo = cell_in.lane[i].z;
      dx = yo >>> step;
      dy = xo >>> step;
      lane_next[i].neg = cell_in.lane[i].neg;
      if (!zo[WORD_W-1]) begin
        lane_next[i].x = xo - dx;
        lane_next[i].y = yo + dy;
        lane_next[i].z = zo - angle_step;
      end else begin
        lane_next[i].x = xo + dx;
        lane_next[i].y = yo - dy;
        lane_next[i].z = zo + angle_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else     valid <= cell_in.valid;
  end

  always_ff @(posedge clk) begin
    lane <= lane_next;
  end

  assign cell_out = '{valid: valid, lane: lane};

endmodule

`default_nettype wire

// File: rtl/ezr_cordic_chain.sv
// Sine/cosine of the three angles: quadrant fold, a row of CORDIC cells,
// then sign fix and clamp. Depends on ezr_pkg and ezr_cordic_cell.
`default_nettype none

module ezr_cordic_chain import ezr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  ezr_angles_t   angles,
  output ezr_trig_bus_t trig_out
);

  ezr_cell_bus_t                 bus [CORDIC_STEPS+1];
  logic                          prep_valid;
  ezr_lane_t [NUM_LANES-1:0]     prep_lane;
  ezr_lane_t [NUM_LANES-1:0]     prep_next;
  logic [NUM_LANES-1:0][ANGLE_BITS-1:0] raw;
  logic                          post_valid;
  ezr_trig_t                     post_trig;
  ezr_trig_t                     post_next;

  assign raw[LANE_YAW]   = angles.yaw_angle;
  assign raw[LANE_PITCH] = angles.pitch_angle;
  assign raw[LANE_ROLL]  = angles.roll_angle;

  // Fold quadrants 1 and 2 by pi so the residual stays within +-pi/2
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      logic [WORD_W-1:0] a;
      logic              flip;
      a    = WORD_W'(raw[i]) << (WORD_W - ANGLE_BITS);
      flip = a[WORD_W-1] ^ a[WORD_W-2];
      prep_next[i].x   = CORDIC_GAIN;
      prep_next[i].y   = '0;
      prep_next[i].z   = signed'({a[WORD_W-1] ^ flip, a[WORD_W-2:0]});
      prep_next[i].neg = flip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) prep_valid <= 1'b0;
    else     prep_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    prep_lane <= prep_next;
  end

  assign bus[0] = '{valid: prep_valid, lane: prep_lane};

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    ezr_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step     (STEP_W'(k)),
      .cell_in  (bus[k]),
      .cell_out (bus[k+1])
    );
  end

  // Undo the fold, then clamp
  always_comb begin
    logic signed [WORD_W-1:0] xs [NUM_LANES];
    logic signed [WORD_W-1:0] ys [NUM_LANES];
    for (int i = 0; i < NUM_LANES; i++) begin
      xs[i] = bus[CORDIC_STEPS].lane[i].neg ? -bus[CORDIC_STEPS].lane[i].x
                                            : bus[CORDIC_STEPS].lane[i].x;
      ys[i] = bus[CORDIC_STEPS].lane[i].neg ? -bus[CORDIC_STEPS].lane[i].y
                                            : bus[CORDIC_STEPS].lane[i].y;
    end
    post_next.cy = clamp_unit(xs[LANE_YAW]);
    post_next.sy = clamp_unit(ys[LANE_YAW]);
    post_next.cp = clamp_unit(xs[LANE_PITCH]);
    post_next.sp = clamp_unit(ys[LANE_PITCH]);
    post_next.cr = clamp_unit(xs[LANE_ROLL]);
    post_next.sr = clamp_unit(ys[LANE_ROLL]);
  end

  always_ff @(posedge clk) begin
    if (rst) post_valid <= 1'b0;
    else     post_valid <= bus[CORDIC_STEPS].valid;
  end

  always_ff @(posedge clk) begin
    post_trig <= post_next;
  end

  assign trig_out = '{valid: post_valid, trig: post_trig};

endmodule

`default_nettype wire

// File: rtl/ezr_matrix.sv
// Product pipeline: nine entries of Rz*Ry*Rx from the six sines/cosines,
// rounded and saturated to the output format. Depends on ezr_pkg.
`default_nettype none

module ezr_matrix import ezr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  ezr_trig_bus_t trig_in,
  output logic          done,
  output ezr_matrix_t   matrix
);

  logic [3:0] valid;

  // stage 1: two-factor products
  logic signed [PROD_W-1:0] p_cysp, p_sysp, p_cycp, p_sycp, p_sycr, p_sysr;
  logic signed [PROD_W-1:0] p_cycr, p_cysr, p_cpsr, p_cpcr;
  logic signed [TRIG_W-1:0] s1_sp, s1_cr, s1_sr;

  // stage 2: pitch/yaw terms back to Q30
  logic signed [TRIG_W-1:0] q_cysp, q_sysp, s2_sp, s2_cr, s2_sr;
  logic signed [PROD_W-1:0] s2_cycp, s2_sycp, s2_sycr, s2_sysr;
  logic signed [PROD_W-1:0] s2_cycr, s2_cysr, s2_cpsr, s2_cpcr;

  // stage 3: triple products
  logic signed [PROD_W-1:0] t_cyspsr, t_cyspcr, t_syspsr, t_syspcr;
  logic signed [PROD_W-1:0] s3_cycp, s3_sycp, s3_sycr, s3_sysr;
  logic signed [PROD_W-1:0] s3_cycr, s3_cysr, s3_cpsr, s3_cpcr;
  logic signed [TRIG_W-1:0] s3_sp;

  // stage 4: Q60 entries
  logic signed [SUM_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      done  <= 1'b0;
    end else begin
      valid <= {valid[2:0], trig_in.valid};
      done  <= valid[3];
    end
  end

  always_ff @(posedge clk) begin
    p_cysp <= trig_in.trig.cy * trig_in.trig.sp;
    p_sysp <= trig_in.trig.sy * trig_in.trig.sp;
    p_cycp <= trig_in.trig.cy * trig_in.trig.cp;
    p_sycp <= trig_in.trig.sy * trig_in.trig.cp;
    p_sycr <= trig_in.trig.sy * trig_in.trig.cr;
    p_sysr <= trig_in.trig.sy * trig_in.trig.sr;
    p_cycr <= trig_in.trig.cy * trig_in.trig.cr;
    p_cysr <= trig_in.trig.cy * trig_in.trig.sr;
    p_cpsr <= trig_in.trig.cp * trig_in.trig.sr;
    p_cpcr <= trig_in.trig.cp * trig_in.trig.cr;
    s1_sp  <= trig_in.trig.sp;
    s1_cr  <= trig_in.trig.cr;
    s1_sr  <= trig_in.trig.sr;

    q_cysp  <= round_q30(p_cysp);
    q_sysp  <= round_q30(p_sysp);
    s2_sp   <= s1_sp;
    s2_cr   <= s1_cr;
    s2_sr   <= s1_sr;
    s2_cycp <= p_cycp;
    s2_sycp <= p_sycp;
    s2_sycr <= p_sycr;
    s2_sysr <= p_sysr;
    s2_cycr <= p_cycr;
    s2_cysr <= p_cysr;
    s2_cpsr <= p_cpsr;
    s2_cpcr <= p_cpcr;

    t_cyspsr <= q_cysp * s2_sr;
    t_cyspcr <= q_cysp * s2_cr;
    t_syspsr <= q_sysp * s2_sr;
    t_syspcr <= q_sysp * s2_cr;
    s3_cycp  <= s2_cycp;
    s3_sycp  <= s2_sycp;
    s3_sycr  <= s2_sycr;
    s3_sysr  <= s2_sysr;
    s3_cycr  <= s2_cycr;
    s3_cysr  <= s2_cysr;
    s3_cpsr  <= s2_cpsr;
    s3_cpcr  <= s2_cpcr;
    s3_sp    <= s2_sp;

    e00 <= SUM_W'(s3_cycp);
    e01 <= SUM_W'(t_cyspsr) - SUM_W'(s3_sycr);
    e02 <= SUM_W'(t_cyspcr) + SUM_W'(s3_sysr);
    e10 <= SUM_W'(s3_sycp);
    e11 <= SUM_W'(t_syspsr) + SUM_W'(s3_cycr);
    e12 <= SUM_W'(t_syspcr) - SUM_W'(s3_cysr);
    e20 <= -(SUM_W'(s3_sp) <<< Q_BITS);
    e21 <= SUM_W'(s3_cpsr);
    e22 <= SUM_W'(s3_cpcr);

    matrix.m00 <= to_q_out(e00);
    matrix.m01 <= to_q_out(e01);
    matrix.m02 <= to_q_out(e02);
    matrix.m10 <= to_q_out(e10);
    matrix.m11 <= to_q_out(e11);
    matrix.m12 <= to_q_out(e12);
    matrix.m20 <= to_q_out(e20);
    matrix.m21 <= to_q_out(e21);
    matrix.m22 <= to_q_out(e22);
  end

endmodule

`default_nettype wire

// File: rtl/ezr_checker.sv
// Port-level checks for euler_zyx_rotation_matrix, bound to the top level.
// Depends on ezr_pkg.
`default_nettype none

module ezr_checker import ezr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input ezr_matrix_t matrix
);

  localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'(1) << FRAC_BITS;

  function automatic logic in_range(input logic signed [OUT_W-1:0] v);
    return (v <= OUT_MAX) && (v >= -OUT_MAX);
  endfunction

  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching input transfer");

  a_saturated: assert property (@(posedge clk) disable iff (rst)
    done |-> in_range(matrix.m00) && in_range(matrix.m01) && in_range(matrix.m02) &&
             in_range(matrix.m10) && in_range(matrix.m11) && in_range(matrix.m12) &&
             in_range(matrix.m20) && in_range(matrix.m21) && in_range(matrix.m22))
    else $error("matrix entry beyond +-1.0");

endmodule

bind euler_zyx_rotation_matrix ezr_checker u_checker (.*);

`default_nettype wire

// File: sim/euler_zyx_rotation_matrix_tb.sv
// Self-checking testbench for euler_zyx_rotation_matrix: drives yaw/pitch/roll
// transfers and checks each matrix against a bit-exact fixed-point CORDIC model.
// Depends on ezr_pkg (transfer structs, widths, LATENCY) and the RTL top level.
module euler_zyx_rotation_matrix_tb;
  import ezr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Run control
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  // Model arithmetic: Q30 trig, Q60 products, entries in Q1.FRAC_BITS
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam longint UNIT_Q30    = 64'sd1 << 30;
  localparam int     ENTRY_SHIFT = 60 - FRAC_BITS;
  localparam int     NUM_ENTRIES = 9;

  // atan(2^-i) as a 32-bit binary angle (2^32 = 2*pi)
  localparam longint ROT_ANGLE [30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
    64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
  };

  // Every DUT input starts at a known value; reset is high from time zero
  logic        clk   = 1'b0;
  logic        rst   = 1'b1;
  logic        start = 1'b0;
  ezr_angles_t angles = '0;
  logic        busy;
  logic        done;
  ezr_matrix_t matrix;

  // Expected matrices, oldest first, one per accepted transfer
  ezr_matrix_t expected_matrices[$];

  int  mismatches = 0;
  int  cycles = 0;
  bit  idle_enable = 1'b1;  // sender inserts random gaps when set

  euler_zyx_rotation_matrix DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .angles (angles),
    .done   (done),
    .matrix (matrix)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Cosine and sine of one angle code in Q30. Codes in the second and third
  // quadrant are rotated by pi first, and the result negated afterwards, so
  // the CORDIC only ever sees residuals within +-pi/2.
  function automatic void cordic_sincos(input logic [ANGLE_BITS-1:0] code,
                                        output longint cosv, output longint sinv);
    logic [31:0] word;
    bit          flip;
    longint      x, y, z, dx, dy;
    word = {code, {(32 - ANGLE_BITS){1'b0}}};
    flip = (word[31:30] == 2'b01) || (word[31:30] == 2'b10);
    if (flip) word = word + 32'h8000_0000;
    z = longint'(signed'(word));
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ROT_ANGLE[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ROT_ANGLE[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cosv = (x > UNIT_Q30) ? UNIT_Q30 : (x < -UNIT_Q30) ? -UNIT_Q30 : x;
    sinv = (y > UNIT_Q30) ? UNIT_Q30 : (y < -UNIT_Q30) ? -UNIT_Q30 : y;
  endfunction

  // Q60 -> Q30 with round half up
  function automatic longint q60_to_q30(input longint p);
    return (p + (64'sd1 << 29)) >>> 30;
  endfunction

  // Q60 -> output entry: round half up, saturate to +-1.0
  function automatic logic [OUT_W-1:0] q60_to_entry(input longint v);
    longint r, lim;
    lim = 64'sd1 << FRAC_BITS;
    r = (v + (64'sd1 << (ENTRY_SHIFT - 1))) >>> ENTRY_SHIFT;
    if (r > lim) r = lim;
    else if (r < -lim) r = -lim;
    return r[OUT_W-1:0];
  endfunction

  // R = Rz(yaw) * Ry(pitch) * Rx(roll)
  function automatic ezr_matrix_t zyx_rotation(input logic [ANGLE_BITS-1:0] yaw,
                                               input logic [ANGLE_BITS-1:0] pitch,
                                               input logic [ANGLE_BITS-1:0] roll);
    longint      cy, sy, cp, sp, cr, sr, cysp, sysp;
    ezr_matrix_t m;
    cordic_sincos(yaw, cy, sy);
    cordic_sincos(pitch, cp, sp);
    cordic_sincos(roll, cr, sr);
    // triple products round the yaw*pitch part to Q30 first
    cysp  = q60_to_q30(cy * sp);
    sysp  = q60_to_q30(sy * sp);
    m.m00 = q60_to_entry(cy * cp);
    m.m01 = q60_to_entry(cysp * sr - sy * cr);
    m.m02 = q60_to_entry(cysp * cr + sy * sr);
    m.m10 = q60_to_entry(sy * cp);
    m.m11 = q60_to_entry(sysp * sr + cy * cr);
    m.m12 = q60_to_entry(sysp * cr - cy * sr);
    m.m20 = q60_to_entry(-sp * UNIT_Q30);
    m.m21 = q60_to_entry(cp * sr);
    m.m22 = q60_to_entry(cp * cr);
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: done marks a one-cycle result, taken at the closing edge.
  // Values are sampled before this edge's updates land, so no race.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [NUM_ENTRIES-1:0][OUT_W-1:0] want, got;
    if (!rst && done === 1'b1) begin
      if (expected_matrices.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result transfer with nothing expected", $realtime);
      end else begin
        want = expected_matrices.pop_front();
        got  = matrix;
        // m00 sits in the top slice, so entry k (row-major) is slice 8-k
        for (int k = 0; k < NUM_ENTRIES; k++) begin
          if (got[NUM_ENTRIES-1-k] !== want[NUM_ENTRIES-1-k]) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: m%0d%0d expected %0d got %0d", $realtime, k / 3, k % 3,
                       $signed(want[NUM_ENTRIES-1-k]), $signed(got[NUM_ENTRIES-1-k]));
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[euler_zyx_rotation_matrix] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Each call begins right after a rising edge. start stays high from
  // one transfer into the next; a gap lowers it in its own step.
  // ---------------------------------------------------------------------------
  task automatic send_angles(input logic [ANGLE_BITS-1:0] yaw,
                             input logic [ANGLE_BITS-1:0] pitch,
                             input logic [ANGLE_BITS-1:0] roll);
    if (idle_enable && $urandom_range(99) < 4) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    angles.yaw_angle   <= yaw;
    angles.pitch_angle <= pitch;
    angles.roll_angle  <= roll;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    expected_matrices.push_back(zyx_rotation(yaw, pitch, roll));
  endtask

  // Hold off the sender until the pipeline has delivered everything
  task automatic wait_pipeline_empty();
    start <= 1'b0;
    @(posedge clk);
    while (expected_matrices.size() != 0) @(posedge clk);
  endtask

  // Mostly uniform codes; the rest cluster around 0, +-pi/2 and pi, where the
  // quadrant fold and the saturation live.
  function automatic logic [ANGLE_BITS-1:0] random_angle();
    logic [ANGLE_BITS-1:0] anchor;
    if ($urandom_range(99) < 70) return ANGLE_BITS'($urandom);
    case ($urandom_range(3))
      0:       anchor = 16'h0000;
      1:       anchor = 16'h4000;
      2:       anchor = 16'hC000;
      default: anchor = 16'h8000;
    endcase
    return anchor + ANGLE_BITS'($urandom_range(8)) - ANGLE_BITS'(4);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Identity, -pi on all axes and on each axis alone (same as +pi), largest positive codes, one mix
  task automatic test_extremes();
    send_angles(16'h0000, 16'h0000, 16'h0000);
    send_angles(16'h8000, 16'h8000, 16'h8000);
    send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_angles(16'h8000, 16'h0000, 16'h0000);
    send_angles(16'h0000, 16'h8000, 16'h0000);
    send_angles(16'h0000, 16'h0000, 16'h8000);
    send_angles(16'h7FFF, 16'h8000, 16'h0001);
  endtask

  // Codes on both sides of +-pi/2, where the fold toggles and cos/sin hit 1.0
  task automatic test_quadrant_edges();
    logic [ANGLE_BITS-1:0] edges [6] = '{16'h3FFF, 16'h4000, 16'h4001,
                                         16'hBFFF, 16'hC000, 16'hC001};
    foreach (edges[i]) begin
      send_angles(edges[i], edges[i], edges[i]);
      send_angles(-edges[i], edges[i], -edges[i]);
    end
  endtask

  // Pitch at +-pi/2: yaw and roll collapse into one rotation
  task automatic test_gimbal_lock();
    send_angles(16'h2000, 16'h4000, 16'hE000);
    send_angles(16'hD120, 16'hC000, 16'h1388);
    send_angles(16'h7FFF, 16'h4000, 16'h7FFF);
    send_angles(16'h0001, 16'hC000, 16'hFFFF);
  endtask

  task automatic test_random_stream(input int count, input bit with_gaps);
    idle_enable = with_gaps;
    repeat (count) send_angles(random_angle(), random_angle(), random_angle());
    idle_enable = 1'b1;
  endtask

  // A burst, then a full stop until every result is back
  task automatic test_drain_pause();
    repeat (40) send_angles(random_angle(), random_angle(), random_angle());
    wait_pipeline_empty();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_quadrant_edges();
    test_gimbal_lock();
    test_random_stream(380, 1'b1);
    test_random_stream(240, 1'b0);  // back-to-back, no gaps
    test_drain_pause();
    test_random_stream(240, 1'b1);

    // drain, then give a stray late result time to show up
    wait_pipeline_empty();
    repeat (LATENCY + 10) @(posedge clk);

    if (mismatches == 0 && expected_matrices.size() == 0) begin
      $display("[euler_zyx_rotation_matrix] OK");
    end else begin
      $display("[euler_zyx_rotation_matrix] ERROR");
    end
    $finish;
  end

endmodule
